// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked out of reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bmmd_pkg.sv
// ----------------------------------------------------------------------------
// Banked memory map decoder package
// Transfer types, target codes, address constants and the bank decode table.
// ----------------------------------------------------------------------------
package bmmd_pkg;

  typedef enum logic [3:0] {
    TGT_RAM    = 4'd0,
    TGT_BASIC  = 4'd1,
    TGT_KERNAL = 4'd2,
    TGT_CHAR   = 4'd3,
    TGT_VIDEO  = 4'd4,
    TGT_SOUND  = 4'd5,
    TGT_COLOUR = 4'd6,
    TGT_IO1    = 4'd7,
    TGT_IO2    = 4'd8,
    TGT_PORT   = 4'd9
  } bmmd_target_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } bmmd_req_t;

  typedef struct packed {
    bmmd_target_t target;
    logic [15:0]  offset;
    logic [7:0]   port_value;
    logic [15:0]  screen_base;
    logic [15:0]  bitmap_base;
    logic         char_in_rom;
    logic [15:0]  char_base;
  } bmmd_rsp_t;

  // Register writes that change the banking or video base state.
  typedef struct packed {
    logic port_wr;
    logic vid_ctrl1_wr;
    logic vid_ctrl2_wr;
    logic vid_memctrl_wr;
    logic io2_bank_wr;
  } bmmd_wr_evt_t;

  // Bank flag bit positions.
  localparam int FL_ARAM = 0;
  localparam int FL_DRAM = 1;
  localparam int FL_ERAM = 2;
  localparam int FL_IO   = 3;

  localparam logic [15:0] ADDR_PORT   = 16'h0001;
  localparam logic [15:0] BASIC_BASE  = 16'hA000;
  localparam logic [15:0] BASIC_LAST  = 16'hBFFF;
  localparam logic [15:0] KERNAL_BASE = 16'hE000;
  localparam logic [15:0] IO_BASE     = 16'hD000;
  localparam logic [15:0] IO_LAST     = 16'hDFFF;
  localparam logic [15:0] VIDEO_LAST  = 16'hD3FF;
  localparam logic [15:0] SOUND_LAST  = 16'hD7FF;
  localparam logic [15:0] COLOUR_BASE = 16'hD800;
  localparam logic [15:0] COLOUR_LAST = 16'hDBFF;
  localparam logic [15:0] IO1_LAST    = 16'hDCFF;
  localparam logic [15:0] IO2_LAST    = 16'hDDFF;

  localparam logic [15:0] VIDEO_MASK = 16'h003F;
  localparam logic [15:0] SOUND_MASK = 16'h001F;
  localparam logic [15:0] IOCH_MASK  = 16'h000F;

  localparam logic [15:0] VID_CTRL1   = 16'h0011;
  localparam logic [15:0] VID_CTRL2   = 16'h0016;
  localparam logic [15:0] VID_MEMCTRL = 16'h0018;
  localparam logic [15:0] IO2_PORTA   = 16'h0000;

  localparam logic [15:0] BITMAP_STEP   = 16'h2000;
  localparam logic [15:0] CHROM_LO_A    = 16'h1000;
  localparam logic [15:0] CHROM_LO_B    = 16'h9000;
  localparam logic [15:0] CHROM_HI_A    = 16'h1800;
  localparam logic [15:0] CHROM_HI_B    = 16'h9800;
  localparam logic [15:0] CHROM_HI_OFFS = 16'h0800;

  localparam logic [7:0]  PORT_RESET = 8'h37;

  // Bank flags for the low three processor port bits.
  function automatic logic [3:0] bank_decode(input logic [2:0] sel);
    logic [3:0] f;
    unique case (sel)
      3'd0:    f = 4'b0111;
      3'd1:    f = 4'b0101;
      3'd2:    f = 4'b0001;
      3'd3:    f = 4'b0000;
      3'd4:    f = 4'b0111;
      3'd5:    f = 4'b1111;
      3'd6:    f = 4'b1011;
      default: f = 4'b1010;
    endcase
    return f;
  endfunction

endpackage

// File: rtl/bmmd_route.sv
// ----------------------------------------------------------------------------
// Address router
// Maps one bus access to its target and mirrored offset and flags the
// register writes that change banking or video state.
// ----------------------------------------------------------------------------
module bmmd_route
  import bmmd_pkg::*;
(
  input  bmmd_req_t    req,
  input  logic [3:0]   bank_flags,
  output bmmd_target_t target,
  output logic [15:0]  offset,
  output bmmd_wr_evt_t evt
);

  logic [15:0] a;
  logic        wr;
  logic        io_area;
  logic [15:0] vid_off;
  logic [15:0] ioch_off;

  assign a        = req.addr;
  assign wr       = req.req_type;
  assign io_area  = bank_flags[FL_IO] && (a >= IO_BASE) && (a <= IO_LAST);
  assign vid_off  = a & VIDEO_MASK;
  assign ioch_off = a & IOCH_MASK;

  always_comb begin
    target = TGT_RAM;
    offset = a;
    evt    = '0;
    if (io_area) begin
      if (a <= VIDEO_LAST) begin
        target = TGT_VIDEO;
        offset = vid_off;
        evt.vid_ctrl1_wr   = wr && (vid_off == VID_CTRL1);
        evt.vid_ctrl2_wr   = wr && (vid_off == VID_CTRL2);
        evt.vid_memctrl_wr = wr && (vid_off == VID_MEMCTRL);
      end else if (a <= SOUND_LAST) begin
        target = TGT_SOUND;
        offset = a & SOUND_MASK;
      end else if (a <= COLOUR_LAST) begin
        target = TGT_COLOUR;
        offset = a - COLOUR_BASE;
      end else if (a <= IO1_LAST) begin
        target = TGT_IO1;
        offset = ioch_off;
      end else if (a <= IO2_LAST) begin
        target = TGT_IO2;
        offset = ioch_off;
        evt.io2_bank_wr = wr && (ioch_off == IO2_PORTA);
      end
    end else if (!wr && !bank_flags[FL_ARAM] && (a >= BASIC_BASE) && (a <= BASIC_LAST)) begin
      target = TGT_BASIC;
      offset = a - BASIC_BASE;
    end else if (!wr && !bank_flags[FL_ERAM] && (a >= KERNAL_BASE)) begin
      target = TGT_KERNAL;
      offset = a - KERNAL_BASE;
    end else if (!wr && !bank_flags[FL_DRAM] && (a >= IO_BASE) && (a <= IO_LAST)) begin
      target = TGT_CHAR;
      offset = a - IO_BASE;
    end else if (a == ADDR_PORT) begin
      target = TGT_PORT;
      offset = '0;
      evt.port_wr = wr;
    end
  end

endmodule

// File: rtl/bmmd_state.sv
// ----------------------------------------------------------------------------
// Banking and video base state
// Holds the processor port, bank flags and video base registers and gives
// the port and video base values as they stand after the current access.
// ----------------------------------------------------------------------------
module bmmd_state
  import bmmd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  bmmd_wr_evt_t evt,
  input  logic [7:0]   wdata,
  output logic [3:0]   bank_flags,
  output logic [7:0]   port_reg_next,
  output logic [15:0]  screen_base_next,
  output logic [15:0]  bitmap_base_next,
  output logic         char_rom_next,
  output logic [15:0]  char_base_next
);

  logic [7:0]  port_reg;
  logic [15:0] video_bank_base;
  logic [7:0]  mem_ctrl_reg;
  logic        bitmap_mode;
  logic [15:0] screen_base_reg;
  logic [15:0] bitmap_base_reg;
  logic        char_rom;
  logic [15:0] char_base;

  logic [3:0]  bank_flags_next;
  logic [15:0] video_bank_base_next;
  logic [7:0]  mem_ctrl_reg_next;
  logic        bitmap_mode_next;

  bmmd_wr_evt_t ev;
  logic         any_upd;
  logic [15:0]  scr_calc;
  logic [15:0]  bmp_calc;
  logic [15:0]  cm;

  assign ev      = step ? evt : '0;
  assign any_upd = ev.vid_ctrl1_wr | ev.vid_ctrl2_wr | ev.vid_memctrl_wr | ev.io2_bank_wr;

  always_comb begin
    port_reg_next        = ev.port_wr ? wdata : port_reg;
    bank_flags_next      = ev.port_wr ? bank_decode(wdata[2:0]) : bank_flags;
    bitmap_mode_next     = ev.vid_ctrl1_wr ? wdata[5] : bitmap_mode;
    mem_ctrl_reg_next    = ev.vid_memctrl_wr ? wdata : mem_ctrl_reg;
    video_bank_base_next = ev.io2_bank_wr ? {~wdata[1:0], 14'd0} : video_bank_base;
  end

  assign scr_calc = video_bank_base_next + {2'd0, mem_ctrl_reg_next[7:4], 10'd0};
  assign bmp_calc = video_bank_base_next + (mem_ctrl_reg_next[3] ? BITMAP_STEP : 16'd0);
  assign cm       = video_bank_base_next + {2'd0, mem_ctrl_reg_next[3:1], 11'd0};

  always_comb begin
    screen_base_next = any_upd ? scr_calc : screen_base_reg;
    bitmap_base_next = bitmap_base_reg;
    char_rom_next    = char_rom;
    char_base_next   = char_base;
    if (any_upd && (bitmap_mode_next || ev.io2_bank_wr)) begin
      bitmap_base_next = bmp_calc;
    end
    if (any_upd && (!bitmap_mode_next || ev.io2_bank_wr)) begin
      // The two character ROM shadow windows take their data from ROM.
      if ((cm == CHROM_HI_A) || (cm == CHROM_HI_B)) begin
        char_rom_next  = 1'b1;
        char_base_next = CHROM_HI_OFFS;
      end else if ((cm == CHROM_LO_A) || (cm == CHROM_LO_B)) begin
        char_rom_next  = 1'b1;
        char_base_next = '0;
      end else begin
        char_rom_next  = 1'b0;
        char_base_next = cm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_reg        <= PORT_RESET;
      bank_flags      <= bank_decode(PORT_RESET[2:0]);
      video_bank_base <= '0;
      mem_ctrl_reg    <= '0;
      bitmap_mode     <= 1'b0;
      screen_base_reg <= '0;
      bitmap_base_reg <= '0;
      char_rom        <= 1'b0;
      char_base       <= '0;
    end else if (step) begin
      port_reg        <= port_reg_next;
      bank_flags      <= bank_flags_next;
      video_bank_base <= video_bank_base_next;
      mem_ctrl_reg    <= mem_ctrl_reg_next;
      bitmap_mode     <= bitmap_mode_next;
      screen_base_reg <= screen_base_next;
      bitmap_base_reg <= bitmap_base_next;
      char_rom        <= char_rom_next;
      char_base       <= char_base_next;
    end
  end

endmodule

// File: rtl/banked_memory_map_decoder_unit.sv
// ----------------------------------------------------------------------------
// Banked memory map decoder unit
// Routes each processor bus access to RAM, a ROM, a device register window
// or the processor port, and tracks the banking and video base state.
// ----------------------------------------------------------------------------
//
//   Channel | Signals                 | Direction | Content
//   --------+-------------------------+-----------+-------------------------
//   req     | req_valid, req_ready    | in        | access type, addr, wdata
//   rsp     | rsp_valid, rsp_ready    | out       | target, offset, state
//
// One transfer is accepted per cycle while req_ready is high. An access is
// held in the input register and then moves into the result register.
// Decode and state update are combinational between the two registers, so
// the rate is one access per cycle while the result is not stalled.
// A stalled result holds the result register and the input register keeps
// one more access; req_ready drops only when both are full. Reset clears
// both valid flags and restores the power-on banking and video state.
// ----------------------------------------------------------------------------
module banked_memory_map_decoder_unit
  import bmmd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  bmmd_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output bmmd_rsp_t rsp
);

  // Input register.
  logic      s0_valid;
  bmmd_req_t s0_req;
  logic      s0_go;

  // Routing and state outputs.
  bmmd_target_t target;
  logic [15:0]  offset;
  bmmd_wr_evt_t evt;
  logic [3:0]   bank_flags;
  logic [7:0]   port_value;
  logic [15:0]  screen_base;
  logic [15:0]  bitmap_base;
  logic         char_in_rom;
  logic [15:0]  char_base;

  // The input register drains whenever the result register is empty or
  // its transfer completes in this cycle.
  assign s0_go     = s0_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s0_valid || s0_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (req_ready) begin
      s0_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      s0_req <= req;
    end
  end

  bmmd_route u_route (
    .req        (s0_req),
    .bank_flags (bank_flags),
    .target     (target),
    .offset     (offset),
    .evt        (evt)
  );

  // State commits only when the access moves into the result register, so
  // a stalled access never updates the banking state twice.
  bmmd_state u_state (
    .clk              (clk),
    .rst              (rst),
    .step             (s0_go),
    .evt              (evt),
    .wdata            (s0_req.wdata),
    .bank_flags       (bank_flags),
    .port_reg_next    (port_value),
    .screen_base_next (screen_base),
    .bitmap_base_next (bitmap_base),
    .char_rom_next    (char_in_rom),
    .char_base_next   (char_base)
  );

  // Result register: results report the state after the access.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s0_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_go) begin
      rsp.target      <= target;
      rsp.offset      <= offset;
      rsp.port_value  <= port_value;
      rsp.screen_base <= screen_base;
      rsp.bitmap_base <= bitmap_base;
      rsp.char_in_rom <= char_in_rom;
      rsp.char_base   <= char_base;
    end
  end

endmodule

// File: rtl/bmmd_checker.sv
// ----------------------------------------------------------------------------
// Decoder port checker
// Concurrent checks on the ports of the decoder unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmmd_checker
  import bmmd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input bmmd_rsp_t rsp
);

  // A stalled result stays offered.
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")

  // A stalled result keeps its payload.
  `ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable(rsp), "rsp changed while stalled")

  // Every accepted access has a result offered once it has passed the input register.
  `ASSERT_NEXT(a_latency, clk, rst, req_valid && req_ready, ##1 rsp_valid, "result missing after transfer")

  // Nothing is offered right after reset.
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !rsp_valid && req_ready, "pipeline not empty after reset")

  // The port has no mirror, its offset is always zero.
  `ASSERT_IMPL(a_port_offset, clk, rst, rsp_valid && (rsp.target == TGT_PORT), rsp.offset == 16'd0, "port offset not zero")

endmodule

bind banked_memory_map_decoder_unit bmmd_checker u_bmmd_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
